// ===== design/bbnb_pkg.sv =====
// Package for the band-pass note bank: fixed widths, control structs and the
// elaboration-time coefficient generator (Q2.30 biquad coefficients).
// No dependencies.
package bbnb_pkg;

  localparam int SAMPLE_W     = 16;
  localparam int DX_W         = SAMPLE_W + 1;
  localparam int Y_W          = 20;
  localparam int AMP_W        = 32;
  localparam int COEF_W       = 32;
  localparam int PAIR_W       = 6;
  localparam int P0_W         = COEF_W + DX_W;
  localparam int P1_W         = COEF_W + Y_W;
  localparam int ACC_W        = 54;
  localparam int Q_SHIFT      = 30;
  localparam int Q_W          = ACC_W - Q_SHIFT;
  localparam int Y_MAX        = 524287;
  localparam int Y_MIN        = -524288;
  localparam int DECAY_W      = 16;
  localparam int FREQ_ENTRIES = 88;

  localparam logic [DECAY_W-1:0] DECAY_Q16 = 16'd62259;
  localparam logic [ACC_W-1:0]   ROUND_HALF = 54'd536870912;

  localparam logic [63:0] Q30_ONE    = 64'd1073741824;
  localparam logic [63:0] Q30_HALF   = 64'd536870912;
  localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;
  localparam logic [63:0] BW_K_Q30   = 64'd3721306;

  // note frequencies in hundredths of Hz, A0 up to C8
  localparam logic [31:0] FREQ_CENTI [FREQ_ENTRIES] = '{
    32'd2750, 32'd2914, 32'd3087,
    32'd3270, 32'd3465, 32'd3671, 32'd3889, 32'd4120, 32'd4365,
    32'd4625, 32'd4900, 32'd5191, 32'd5500, 32'd5827, 32'd6174,
    32'd6541, 32'd6930, 32'd7342, 32'd7778, 32'd8241, 32'd8731,
    32'd9250, 32'd9800, 32'd10383, 32'd11000, 32'd11654, 32'd12347,
    32'd13081, 32'd13859, 32'd14683, 32'd15556, 32'd16481, 32'd17461,
    32'd18500, 32'd19600, 32'd20765, 32'd22000, 32'd23308, 32'd24694,
    32'd26163, 32'd27718, 32'd29366, 32'd31113, 32'd32963, 32'd34923,
    32'd36999, 32'd39200, 32'd41530, 32'd44000, 32'd46616, 32'd49388,
    32'd52325, 32'd55437, 32'd58733, 32'd62225, 32'd65926, 32'd69846,
    32'd73999, 32'd78399, 32'd83061, 32'd88000, 32'd93233, 32'd98777,
    32'd104650, 32'd110873, 32'd117466, 32'd124451, 32'd131851, 32'd139691,
    32'd147998, 32'd156798, 32'd166122, 32'd176000, 32'd186466, 32'd197553,
    32'd209300, 32'd221746, 32'd234932, 32'd248902, 32'd263702, 32'd279383,
    32'd295996, 32'd313596, 32'd332244, 32'd352000, 32'd372931, 32'd395107,
    32'd418601
  };

  typedef struct packed {
    logic signed [COEF_W-1:0] b0;
    logic signed [COEF_W-1:0] a1;
    logic signed [COEF_W-1:0] a2;
  } coef_t;

  // controller -> datapath
  typedef struct packed {
    logic start;   // sample beat taken
    logic issue;   // note enters the filter pipe
    logic decay;   // first sample of a block: scale amplitude first
    logic rep_rd;  // read amplitude pair for the report
    logic load;    // load result register
    logic last;    // final pair of the report
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic busy;      // filter pipe holds notes
    logic out_fire;  // result beat taken
  } st_t;

  function automatic logic [63:0] qmul(input logic [63:0] a, input logic [63:0] b);
    return (a * b + Q30_HALF) >> 30;
  endfunction

  // shift-subtract quotient, only evaluated while building the coefficient table
  function automatic logic [63:0] cdiv(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    int          i;
    quo = '0;
    rem = '0;
    if (den == 64'd0) begin
      return 64'd0;
    end
    for (i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Constant-peak band-pass coefficients for one note, evaluated at elaboration.
  function automatic coef_t coef_calc(input int note);
    coef_t       res;
    int          fi;
    int          k;
    logic [63:0] fc, w, w2, ts, tc, s, c, ns, nc, r, u, sh, alpha, a0, q;
    fi = (note < FREQ_ENTRIES) ? note : FREQ_ENTRIES - 1;
    fc = 64'(FREQ_CENTI[fi]);
    w  = cdiv(TWO_PI_Q30 * fc + 64'd2205000, 64'd4410000);
    w2 = qmul(w, w);
    ts = w;
    s  = w;
    ns = 64'd1;
    tc = Q30_ONE;
    c  = Q30_ONE;
    nc = 64'd0;
    for (k = 0; k < 5; k++) begin
      ts = cdiv(qmul(ts, w2), (ns + 64'd1) * (ns + 64'd2));
      tc = cdiv(qmul(tc, w2), (nc + 64'd1) * (nc + 64'd2));
      ns = ns + 64'd2;
      nc = nc + 64'd2;
      if (k[0]) begin
        s = s + ts;
        c = c + tc;
      end else begin
        s = s - ts;
        c = c - tc;
      end
    end
    if (s == 64'd0) begin
      r = Q30_ONE;
    end else begin
      r = cdiv((w << 30) + (s >> 1), s);
    end
    u     = qmul(BW_K_Q30, r);
    sh    = u + cdiv(qmul(qmul(u, u), u), 64'd6);
    alpha = qmul(s, sh);
    a0    = Q30_ONE + alpha;
    q      = cdiv((alpha << 30) + (a0 >> 1), a0);
    res.b0 = q[COEF_W-1:0];
    q      = 64'd0 - cdiv(((c << 1) << 30) + (a0 >> 1), a0);
    res.a1 = q[COEF_W-1:0];
    q      = cdiv(((Q30_ONE - alpha) << 30) + (a0 >> 1), a0);
    res.a2 = q[COEF_W-1:0];
    return res;
  endfunction

endpackage

// ===== design/bbnb_ctrl.sv =====
// Sequencer for the band-pass note bank: sample handshake, note issue,
// pipe drain, block counting and the pair report. Uses bbnb_pkg.
module bbnb_ctrl #(
  parameter int NOTE_COUNT    = 88,
  parameter int BLOCK_SAMPLES = 128,
  parameter int NW            = 7,
  parameter int PW            = 6
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output bbnb_pkg::cmd_t   cmd,
  output logic [NW-1:0]    rd_note,
  output logic [PW-1:0]    pair,
  input  bbnb_pkg::st_t    st
);

  localparam int PAIRS = (NOTE_COUNT + 1) / 2;
  localparam int CW    = (BLOCK_SAMPLES > 1) ? $clog2(BLOCK_SAMPLES) : 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RUN   = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_RD    = 3'd3;
  localparam logic [2:0] S_LD    = 3'd4;
  localparam logic [2:0] S_SEND  = 3'd5;

  logic [2:0]    state_r, state_nxt;
  logic [NW-1:0] note_r, note_nxt;
  logic [PW-1:0] pair_r, pair_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          decay_r, decay_nxt;
  logic          last_pair;

  assign last_pair = (pair_r == PW'(PAIRS - 1));
  assign pair      = pair_r;

  always_comb begin
    state_nxt = state_r;
    note_nxt  = note_r;
    pair_nxt  = pair_r;
    cnt_nxt   = cnt_r;
    decay_nxt = decay_r;
    in_ready  = 1'b0;
    cmd       = '0;
    rd_note   = note_r;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start = 1'b1;
          decay_nxt = (cnt_r == '0);
          note_nxt  = '0;
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        cmd.issue = 1'b1;
        cmd.decay = decay_r;
        if (note_r == NW'(NOTE_COUNT - 1)) begin
          state_nxt = S_DRAIN;
        end else begin
          note_nxt = note_r + 1'b1;
        end
      end
      S_DRAIN: begin
        if (!st.busy) begin
          if (cnt_r == CW'(BLOCK_SAMPLES - 1)) begin
            cnt_nxt   = '0;
            pair_nxt  = '0;
            state_nxt = S_RD;
          end else begin
            cnt_nxt   = cnt_r + 1'b1;
            state_nxt = S_IDLE;
          end
        end
      end
      S_RD: begin
        cmd.rep_rd = 1'b1;
        rd_note    = NW'({pair_r, 1'b0});
        state_nxt  = S_LD;
      end
      S_LD: begin
        cmd.load  = 1'b1;
        cmd.last  = last_pair;
        state_nxt = S_SEND;
      end
      S_SEND: begin
        if (st.out_fire) begin
          if (last_pair) begin
            state_nxt = S_IDLE;
          end else begin
            pair_nxt  = pair_r + 1'b1;
            state_nxt = S_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      note_r  <= '0;
      pair_r  <= '0;
      cnt_r   <= '0;
      decay_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      note_r  <= note_nxt;
      pair_r  <= pair_nxt;
      cnt_r   <= cnt_nxt;
      decay_r <= decay_nxt;
    end
  end

`ifndef SYNTHESIS
  a_busy_not_idle: assert property (@(posedge clk) disable iff (!rst_n)
    st.busy |-> (state_r == S_DRAIN || state_r == S_RUN))
    else $error("filter pipe busy outside a sample pass");

  a_fire_in_send: assert property (@(posedge clk) disable iff (!rst_n)
    st.out_fire |-> (state_r == S_SEND))
    else $error("result beat taken outside report send");

  a_issue_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.issue |-> (note_r <= NW'(NOTE_COUNT - 1)))
    else $error("note index past the bank");
`endif

endmodule

// ===== design/bbnb_dp.sv =====
// Datapath for the band-pass note bank: coefficient table, per-note state
// memories, 4-stage biquad pipe and the result register. Uses bbnb_pkg.
module bbnb_dp #(
  parameter int NOTE_COUNT = 88,
  parameter int NW         = 7,
  parameter int PW         = 6
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic signed [bbnb_pkg::SAMPLE_W-1:0]  in_sample,
  input  bbnb_pkg::cmd_t                        cmd,
  input  logic [NW-1:0]                         rd_note,
  input  logic [PW-1:0]                         pair,
  output bbnb_pkg::st_t                         st,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [bbnb_pkg::PAIR_W-1:0]           out_pair_index,
  output logic [bbnb_pkg::AMP_W-1:0]            out_amp_even,
  output logic [bbnb_pkg::AMP_W-1:0]            out_amp_odd,
  output logic                                  out_last
);

  localparam int SAMPLE_W = bbnb_pkg::SAMPLE_W;
  localparam int DX_W     = bbnb_pkg::DX_W;
  localparam int Y_W      = bbnb_pkg::Y_W;
  localparam int AMP_W    = bbnb_pkg::AMP_W;
  localparam int P0_W     = bbnb_pkg::P0_W;
  localparam int P1_W     = bbnb_pkg::P1_W;
  localparam int ACC_W    = bbnb_pkg::ACC_W;
  localparam int Q_SHIFT  = bbnb_pkg::Q_SHIFT;
  localparam int Q_W      = bbnb_pkg::Q_W;
  localparam int PAIR_W   = bbnb_pkg::PAIR_W;
  localparam int DECAY_W  = bbnb_pkg::DECAY_W;
  localparam int PAIRS    = (NOTE_COUNT + 1) / 2;

  // coefficient table, built at elaboration
  bbnb_pkg::coef_t rom_w [NOTE_COUNT];
  for (genvar g = 0; g < NOTE_COUNT; g++) begin : g_rom
    localparam bbnb_pkg::coef_t C = bbnb_pkg::coef_calc(g);
    assign rom_w[g] = C;
  end

  // per-note state; entries never written read as zero via vld_r
  logic signed [Y_W-1:0] y1_mem  [NOTE_COUNT];
  logic signed [Y_W-1:0] y2_mem  [NOTE_COUNT];
  logic [AMP_W-1:0]      amp_mem [NOTE_COUNT];
  logic [NOTE_COUNT-1:0] vld_r;

  logic signed [SAMPLE_W-1:0] xp1_r, xp2_r;
  logic signed [DX_W-1:0]     dx_r;

  // second read port address: odd note of the pair
  logic [NW:0]   nb_w;
  logic          odd_ok;
  logic [NW-1:0] addr_b;

  assign nb_w   = {1'b0, rd_note} + 1'b1;
  assign odd_ok = (nb_w < (NW+1)'(NOTE_COUNT));
  assign addr_b = odd_ok ? nb_w[NW-1:0] : '0;

  // stage 1: memory and table outputs
  logic                       s1_v_r, s1_decay_r;
  logic [NW-1:0]              s1_note_r;
  bbnb_pkg::coef_t            s1_coef_r;
  logic signed [Y_W-1:0]      rd_y1_r, rd_y2_r;
  logic [AMP_W-1:0]           rd_amp_a_r, rd_amp_b_r;
  logic                       rd_vld_a_r, rd_vld_b_r;

  logic signed [Y_W-1:0]      y1_w, y2_w;
  logic [AMP_W-1:0]           amp_w, amp_dec_w;
  logic [AMP_W+DECAY_W-1:0]   dec_prod_w;
  logic signed [P0_W-1:0]     p0_w;
  logic signed [P1_W-1:0]     p1_w, p2_w;

  // stage 2
  logic                       s2_v_r;
  logic [NW-1:0]              s2_note_r;
  logic signed [P0_W-1:0]     s2_p0_r;
  logic signed [P1_W-1:0]     s2_p1_r, s2_p2_r;
  logic [AMP_W-1:0]           s2_amp_r;
  logic signed [Y_W-1:0]      s2_y1_r;

  // stage 3
  logic                       s3_v_r;
  logic [NW-1:0]              s3_note_r;
  logic signed [ACC_W-1:0]    s3_sum_r;
  logic signed [P1_W-1:0]     s3_p2_r;
  logic [AMP_W-1:0]           s3_amp_r;
  logic signed [Y_W-1:0]      s3_y1_r;
  logic signed [ACC_W-1:0]    acc_w;
  logic signed [Q_W-1:0]      q_w;
  logic signed [Y_W-1:0]      y_sat_w;

  // stage 4: write back
  logic                       s4_v_r;
  logic [NW-1:0]              s4_note_r;
  logic signed [Y_W-1:0]      s4_y_r, s4_y1_r;
  logic [AMP_W-1:0]           s4_amp_r;
  logic [Y_W-1:0]             mag_w;
  logic [AMP_W:0]             sum_w;
  logic [AMP_W-1:0]           amp_new_w;

  logic                       out_valid_r;
  logic [PAIR_W-1:0]          out_pair_r;
  logic [AMP_W-1:0]           out_even_r, out_odd_r;
  logic                       out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xp1_r <= '0;
      xp2_r <= '0;
    end else if (cmd.start) begin
      xp2_r <= xp1_r;
      xp1_r <= in_sample;
    end
  end

  // b0 multiplies x - x_prev2, the same for every note of this sample
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      dx_r <= DX_W'(in_sample) - DX_W'(xp2_r);
    end
  end

  always_ff @(posedge clk) begin
    rd_y1_r    <= y1_mem[rd_note];
    rd_y2_r    <= y2_mem[rd_note];
    rd_amp_a_r <= amp_mem[rd_note];
    rd_amp_b_r <= amp_mem[addr_b];
    rd_vld_a_r <= vld_r[rd_note];
    rd_vld_b_r <= odd_ok && vld_r[addr_b];
    s1_note_r  <= rd_note;
    s1_decay_r <= cmd.decay;
    s1_coef_r  <= rom_w[rd_note];
  end

  assign y1_w       = rd_vld_a_r ? rd_y1_r : '0;
  assign y2_w       = rd_vld_a_r ? rd_y2_r : '0;
  assign amp_w      = rd_vld_a_r ? rd_amp_a_r : '0;
  assign dec_prod_w = (AMP_W+DECAY_W)'(amp_w) * (AMP_W+DECAY_W)'(bbnb_pkg::DECAY_Q16);
  assign amp_dec_w  = s1_decay_r ? dec_prod_w[AMP_W+DECAY_W-1:DECAY_W] : amp_w;
  assign p0_w       = P0_W'(s1_coef_r.b0) * P0_W'(dx_r);
  assign p1_w       = P1_W'(s1_coef_r.a1) * P1_W'(y1_w);
  assign p2_w       = P1_W'(s1_coef_r.a2) * P1_W'(y2_w);

  always_ff @(posedge clk) begin
    s2_note_r <= s1_note_r;
    s2_p0_r   <= p0_w;
    s2_p1_r   <= p1_w;
    s2_p2_r   <= p2_w;
    s2_amp_r  <= amp_dec_w;
    s2_y1_r   <= y1_w;
  end

  always_ff @(posedge clk) begin
    s3_note_r <= s2_note_r;
    s3_sum_r  <= ACC_W'(s2_p0_r) - ACC_W'(s2_p1_r);
    s3_p2_r   <= s2_p2_r;
    s3_amp_r  <= s2_amp_r;
    s3_y1_r   <= s2_y1_r;
  end

  // round half up in Q.30, floor via arithmetic shift, clamp to Q5.15
  assign acc_w = s3_sum_r - ACC_W'(s3_p2_r) + $signed(bbnb_pkg::ROUND_HALF);
  assign q_w   = acc_w[ACC_W-1:Q_SHIFT];

  always_comb begin
    if (q_w > Q_W'(bbnb_pkg::Y_MAX)) begin
      y_sat_w = Y_W'(bbnb_pkg::Y_MAX);
    end else if (q_w < Q_W'(bbnb_pkg::Y_MIN)) begin
      y_sat_w = Y_W'(bbnb_pkg::Y_MIN);
    end else begin
      y_sat_w = q_w[Y_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    s4_note_r <= s3_note_r;
    s4_y_r    <= y_sat_w;
    s4_y1_r   <= s3_y1_r;
    s4_amp_r  <= s3_amp_r;
  end

  assign mag_w     = s4_y_r[Y_W-1] ? (Y_W'(0) - s4_y_r) : s4_y_r;
  assign sum_w     = {1'b0, s4_amp_r} + (AMP_W+1)'(mag_w);
  assign amp_new_w = sum_w[AMP_W] ? '1 : sum_w[AMP_W-1:0];

  always_ff @(posedge clk) begin
    if (s4_v_r) begin
      y1_mem[s4_note_r]  <= s4_y_r;
      y2_mem[s4_note_r]  <= s4_y1_r;
      amp_mem[s4_note_r] <= amp_new_w;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      vld_r  <= '0;
    end else begin
      s1_v_r <= cmd.issue;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
      if (s4_v_r) begin
        vld_r[s4_note_r] <= 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_pair_r <= PAIR_W'(pair);
      out_even_r <= rd_vld_a_r ? rd_amp_a_r : '0;
      out_odd_r  <= rd_vld_b_r ? rd_amp_b_r : '0;
      out_last_r <= cmd.last;
    end
  end

  assign st.busy        = s1_v_r | s2_v_r | s3_v_r | s4_v_r;
  assign st.out_fire    = out_valid_r & out_ready;
  assign out_valid      = out_valid_r;
  assign out_pair_index = out_pair_r;
  assign out_amp_even   = out_even_r;
  assign out_amp_odd    = out_odd_r;
  assign out_last       = out_last_r;

`ifndef SYNTHESIS
  a_wr_range: assert property (@(posedge clk) disable iff (!rst_n)
    s4_v_r |-> (s4_note_r <= NW'(NOTE_COUNT - 1)))
    else $error("write-back past the note bank");

  a_rep_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rep_rd |-> !st.busy)
    else $error("report read while filter writes pending");

  a_last_pair: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> (out_pair_r == PAIR_W'(PAIRS - 1)))
    else $error("last flag on wrong pair");

  a_load_idle_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> !out_valid_r)
    else $error("result register overwritten before beat taken");
`endif

endmodule

// ===== design/biquad_bandpass_note_bank_top.sv =====
// Band-pass note bank top level. Each sample beat (signed Q1.15) is run
// through NOTE_COUNT constant-peak biquad band-pass filters, one per piano
// note, with Q2.30 coefficients fixed at build time. The magnitude of each
// Q5.15 filter output is added into that note's 32-bit saturating amplitude;
// the first sample of every BLOCK_SAMPLES block scales all amplitudes by
// 0.95 beforehand. After the last sample of a block the amplitudes leave as
// (NOTE_COUNT+1)/2 result beats of note pairs, out_last on the final one.
// Notes go one per cycle through a 4-stage filter pipe that reads and writes
// per-note state memories; in_ready returns once the pipe has drained, or
// after the block report for the last sample of a block. Each report pair
// takes a memory read, a result load and a beat. No clearing pass is needed
// after reset. Uses bbnb_pkg, bbnb_ctrl and bbnb_dp.
module biquad_bandpass_note_bank_top #(
  parameter int NOTE_COUNT    = 88,
  parameter int BLOCK_SAMPLES = 128
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [bbnb_pkg::SAMPLE_W-1:0]  in_sample,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [bbnb_pkg::PAIR_W-1:0]           out_pair_index,
  output logic [bbnb_pkg::AMP_W-1:0]            out_amp_even,
  output logic [bbnb_pkg::AMP_W-1:0]            out_amp_odd,
  output logic                                  out_last
);

  localparam int PAIRS = (NOTE_COUNT + 1) / 2;
  localparam int NW    = (NOTE_COUNT > 1) ? $clog2(NOTE_COUNT) : 1;
  localparam int PW    = (PAIRS > 1) ? $clog2(PAIRS) : 1;

  bbnb_pkg::cmd_t cmd;
  bbnb_pkg::st_t  st;
  logic [NW-1:0]  rd_note;
  logic [PW-1:0]  pair;

  bbnb_ctrl #(
    .NOTE_COUNT    (NOTE_COUNT),
    .BLOCK_SAMPLES (BLOCK_SAMPLES),
    .NW            (NW),
    .PW            (PW)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .rd_note  (rd_note),
    .pair     (pair),
    .st       (st)
  );

  bbnb_dp #(
    .NOTE_COUNT (NOTE_COUNT),
    .NW         (NW),
    .PW         (PW)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_sample      (in_sample),
    .cmd            (cmd),
    .rd_note        (rd_note),
    .pair           (pair),
    .st             (st),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_pair_index (out_pair_index),
    .out_amp_even   (out_amp_even),
    .out_amp_odd    (out_amp_odd),
    .out_last       (out_last)
  );

endmodule
